// ----- sv/svna_pkg.sv -----
// ----------------------------------------------------------------------------
// svna_pkg: shared types and constants
// Operation codes, the command that travels from the front to the back,
// status codes, the cross-product schedule and the saturating sum update.
// ----------------------------------------------------------------------------
package svna_pkg;

  localparam int IDX_IO_W = 12;
  localparam int POS_W    = 32;
  localparam int Q14_W    = 16;
  localparam int ONE_Q14  = 16384;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI  = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_VERT = 2'd2;

  typedef struct packed {
    op_e                       op;
    logic                      in_range;
    logic [IDX_IO_W-1:0]       index;
    logic signed [POS_W-1:0]   px;
    logic signed [POS_W-1:0]   py;
    logic signed [POS_W-1:0]   pz;
    logic [IDX_IO_W-1:0]       ca;
    logic [IDX_IO_W-1:0]       cb;
    logic [IDX_IO_W-1:0]       cc;
  } cmd_t;

  // Cross product e = d(b-a) x d(c-a) as six signed products.
  // Differences 0..2 are b-a, 3..5 are c-a.
  localparam logic [2:0] MUL_A   [6] = '{3'd1, 3'd2, 3'd2, 3'd0, 3'd0, 3'd1};
  localparam logic [2:0] MUL_B   [6] = '{3'd5, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3};
  localparam logic [1:0] MUL_DST [6] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic       MUL_NEG [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  // Add a Q1.14 component to a 32-bit sum, clamp at the signed limits.
  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0] s,
    input logic signed [Q14_W-1:0] n
  );
    logic signed [POS_W:0] t;
    t = (POS_W+1)'(s) + (POS_W+1)'(n);
    if (t[POS_W] != t[POS_W-1]) begin
      sat_add = t[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sat_add = t[POS_W-1:0];
    end
  endfunction

endpackage

// ----- sv/svna_if.sv -----
// ----------------------------------------------------------------------------
// svna_if: channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface svna_in_if;
  logic                                        valid;
  logic                                        ready;
  logic [1:0]                                  operation;
  logic [svna_pkg::IDX_IO_W-1:0]               vertex_index;
  logic signed [svna_pkg::POS_W-1:0]           pos_x;
  logic signed [svna_pkg::POS_W-1:0]           pos_y;
  logic signed [svna_pkg::POS_W-1:0]           pos_z;
  logic [svna_pkg::IDX_IO_W-1:0]               corner_a;
  logic [svna_pkg::IDX_IO_W-1:0]               corner_b;
  logic [svna_pkg::IDX_IO_W-1:0]               corner_c;

  modport source (output valid, operation, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, operation, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

interface svna_out_if;
  logic                                        valid;
  logic                                        ready;
  logic [svna_pkg::IDX_IO_W-1:0]               read_index;
  logic signed [svna_pkg::Q14_W-1:0]           normal_x;
  logic signed [svna_pkg::Q14_W-1:0]           normal_y;
  logic signed [svna_pkg::Q14_W-1:0]           normal_z;
  logic signed [svna_pkg::Q14_W-1:0]           tangent_x;
  logic signed [svna_pkg::Q14_W-1:0]           tangent_y;
  logic signed [svna_pkg::Q14_W-1:0]           tangent_z;
  logic [1:0]                                  status;

  modport source (output valid, read_index, normal_x, normal_y, normal_z,
                  tangent_x, tangent_y, tangent_z, status, input ready);
  modport sink   (input valid, read_index, normal_x, normal_y, normal_z,
                  tangent_x, tangent_y, tangent_z, status, output ready);
endinterface

// ----- sv/svna_front.sv -----
// ----------------------------------------------------------------------------
// svna_front: request intake
// Accepts request beats, drops the ones that do nothing and queues the rest
// in a two-entry buffer for the back end.
// ----------------------------------------------------------------------------
module svna_front #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  svna_in_if.sink          in_i,
  input  logic             clearing_i,
  output logic             cmd_valid_o,
  output svna_pkg::cmd_t   cmd_o,
  input  logic             cmd_ready_i
);

  svna_pkg::cmd_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  svna_pkg::cmd_t cmd_new;
  logic           keep, push, pop;
  logic           vi_ok, a_ok, b_ok, c_ok;

  // Classify the incoming beat
  always_comb begin
    vi_ok = 32'(in_i.vertex_index) < VERTEX_DEPTH;
    a_ok  = 32'(in_i.corner_a) < VERTEX_DEPTH;
    b_ok  = 32'(in_i.corner_b) < VERTEX_DEPTH;
    c_ok  = 32'(in_i.corner_c) < VERTEX_DEPTH;
    cmd_new.op       = svna_pkg::op_e'(in_i.operation);
    cmd_new.in_range = vi_ok;
    cmd_new.index    = in_i.vertex_index;
    cmd_new.px       = in_i.pos_x;
    cmd_new.py       = in_i.pos_y;
    cmd_new.pz       = in_i.pos_z;
    cmd_new.ca       = in_i.corner_a;
    cmd_new.cb       = in_i.corner_b;
    cmd_new.cc       = in_i.corner_c;
    case (cmd_new.op)
      svna_pkg::OP_LOAD: keep = vi_ok;
      svna_pkg::OP_TRI:  keep = a_ok && b_ok && c_ok;
      svna_pkg::OP_READ: keep = 1'b1;
      default:           keep = 1'b0;
    endcase
  end

  assign in_i.ready  = !clearing_i && (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready && keep;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = mem_q[rp_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cmd_new;
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_fill_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue fill level did not advance on push");
`endif

endmodule

// ----- sv/svna_norm.sv -----
// ----------------------------------------------------------------------------
// svna_norm: iterative vector normalizer
// Scales three magnitudes into [2^29, 2^30), sums the squares, takes an
// integer square root bit by bit and divides each component by the length
// with a restoring divider to a rounded Q1.14 result.
// ----------------------------------------------------------------------------
module svna_norm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [63:0]                   vec_i [3],
  output logic                                 done_o,
  output logic                                 nonzero_o,
  output logic signed [svna_pkg::Q14_W-1:0]    unit_o [3]
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SCALE = 6'b000010,
    N_SQ    = 6'b000100,
    N_ROOT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_e;

  nstate_e      state_q, state_d;
  logic         neg_q [3], neg_d [3];
  logic [63:0]  mag_q [3], mag_d [3];
  logic [4:0]   cnt_q, cnt_d;
  logic [1:0]   cmp_q, cmp_d;
  logic [59:0]  prod_q, prod_d;
  logic [61:0]  acc_q, acc_d;
  logic [62:0]  rem_q, rem_d, res_q, res_d, bit_q, bit_d;
  logic [46:0]  num_q, num_d, den_q, den_d;
  logic [15:0]  quo_q, quo_d;
  logic signed [15:0] unit_q [3], unit_d [3];
  logic         nz_q, nz_d;

  logic         big_hi, big_lo, ge;
  logic [1:0]   sq_sel;
  logic [62:0]  trial;
  logic [30:0]  len;
  logic [15:0]  qfin;

  assign done_o    = (state_q == N_DONE);
  assign nonzero_o = nz_q;
  assign unit_o    = unit_q;
  assign len       = res_q[30:0];

  always_comb begin
    big_hi = |{mag_q[0][63:30], mag_q[1][63:30], mag_q[2][63:30]};
    big_lo = ~|{mag_q[0][63:29], mag_q[1][63:29], mag_q[2][63:29]};
    sq_sel = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
    trial  = res_q + bit_q;
    ge     = num_q >= den_q;
    qfin   = {quo_q[14:0], ge};
  end

  // Sequence the normalization steps
  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    cmp_d   = cmp_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    res_d   = res_q;
    bit_d   = bit_q;
    num_d   = num_q;
    den_d   = den_q;
    quo_d   = quo_q;
    unit_d  = unit_q;
    nz_d    = nz_q;
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_d[i]  = vec_i[i] < 0;
            mag_d[i]  = (vec_i[i] < 0) ? 64'(-vec_i[i]) : 64'(vec_i[i]);
            unit_d[i] = '0;
          end
          nz_d = (vec_i[0] != 0) || (vec_i[1] != 0) || (vec_i[2] != 0);
          state_d = nz_d ? N_SCALE : N_DONE;
        end
      end
      N_SCALE: begin
        // Shift one bit a cycle toward [2^29, 2^30)
        if (big_hi) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (big_lo) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          cnt_d   = '0;
          acc_d   = '0;
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        if (cnt_q[1:0] != 2'd3) begin
          prod_d = mag_q[sq_sel][29:0] * mag_q[sq_sel][29:0];
        end
        if (cnt_q != 5'd0) begin
          acc_d = acc_q + 62'(prod_q);
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[1:0] == 2'd3) begin
          rem_d   = 63'(acc_d);
          res_d   = '0;
          bit_d   = 63'(1) << 60;
          state_d = N_ROOT;
        end
      end
      N_ROOT: begin
        // One result bit a cycle
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          cnt_d   = '0;
          cmp_d   = '0;
          state_d = N_DIV;
        end
      end
      N_DIV: begin
        if (cnt_q == 5'd0) begin
          num_d = 47'({mag_q[cmp_q][29:0], 14'd0}) + 47'(len >> 1);
          den_d = 47'(len) << 15;
          quo_d = '0;
          cnt_d = 5'd1;
        end else begin
          if (ge) num_d = num_q - den_q;
          den_d = den_q >> 1;
          quo_d = qfin;
          cnt_d = cnt_q + 5'd1;
          if (cnt_q == 5'd16) begin
            unit_d[cmp_q] = neg_q[cmp_q] ? -$signed(qfin) : $signed(qfin);
            cnt_d = '0;
            if (cmp_q == 2'd2) begin
              state_d = N_DONE;
            end else begin
              cmp_d = cmp_q + 2'd1;
            end
          end
        end
      end
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    cmp_q  <= cmp_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    num_q  <= num_d;
    den_q  <= den_d;
    quo_q  <= quo_d;
    unit_q <= unit_d;
    nz_q   <= nz_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == N_IDLE)
    else $error("normalizer started while busy");
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && nz_q) |->
      (unit_q[0] <= 16'sd16384) && (unit_q[0] >= -16'sd16384) &&
      (unit_q[1] <= 16'sd16384) && (unit_q[1] >= -16'sd16384) &&
      (unit_q[2] <= 16'sd16384) && (unit_q[2] >= -16'sd16384))
    else $error("normalized component exceeds one");
`endif

endmodule

// ----- sv/svna_back.sv -----
// ----------------------------------------------------------------------------
// svna_back: command execution
// Holds the position and normal-sum memories, clears the sums after reset,
// runs triangle accumulation and vertex reads through a shared normalizer,
// and keeps the result in an output register.
// ----------------------------------------------------------------------------
module svna_back #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  svna_pkg::cmd_t   cmd_i,
  output logic             cmd_ready_o,
  output logic             clearing_o,
  svna_out_if.source       out_o
);

  localparam int IDX_W = $clog2(VERTEX_DEPTH);

  typedef enum logic [12:0] {
    B_CLEAR = 13'b0000000000001,
    B_IDLE  = 13'b0000000000010,
    T_FETCH = 13'b0000000000100,
    T_DIFF  = 13'b0000000001000,
    T_SCALE = 13'b0000000010000,
    T_MUL   = 13'b0000000100000,
    T_NORM  = 13'b0000001000000,
    T_RD    = 13'b0000010000000,
    T_WR    = 13'b0000100000000,
    R_FETCH = 13'b0001000000000,
    R_NORM  = 13'b0010000000000,
    R_TAN   = 13'b0100000000000,
    R_OUT   = 13'b1000000000000
  } bstate_e;

  logic [95:0] pos_mem [VERTEX_DEPTH];
  logic [95:0] sum_mem [VERTEX_DEPTH];

  bstate_e        state_q, state_d;
  svna_pkg::cmd_t cur_q, cur_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic [2:0]     cnt_q, cnt_d;
  logic [1:0]     j_q, j_d;
  logic           nstart_q, nstart_d;
  logic [95:0]    pos_rd_q, sum_rd_q, rsum_q, rsum_d;
  logic [95:0]    vtx_q [3], vtx_d [3];
  logic           dneg_q [6], dneg_d [6];
  logic [32:0]    dmag_q [6], dmag_d [6];
  logic signed [61:0] prod_q, prod_d;
  logic signed [63:0] e_q [3], e_d [3];
  logic signed [15:0] nrm_q [3], nrm_d [3];
  logic signed [15:0] tan_q [3], tan_d [3];
  logic [1:0]     st_q, st_d;

  logic           out_valid_q, out_valid_d;
  logic [svna_pkg::IDX_IO_W-1:0] oidx_q, oidx_d;
  logic signed [15:0] on_q [3], on_d [3];
  logic signed [15:0] ot_q [3], ot_d [3];
  logic [1:0]     ost_q, ost_d;

  logic [IDX_W-1:0] pos_raddr, sum_raddr, sum_waddr;
  logic           pos_we, sum_we;
  logic [95:0]    sum_wdata;
  logic [svna_pkg::IDX_IO_W-1:0] corner;
  logic signed [30:0] sd [6];
  logic signed [63:0] nvec [3];
  logic           ndone, nnz;
  logic signed [15:0] nunit [3];
  logic [2:0]     msel;
  logic signed [32:0] diff;
  logic           big_hi;

  svna_norm u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (nstart_q),
    .vec_i     (nvec),
    .done_o    (ndone),
    .nonzero_o (nnz),
    .unit_o    (nunit)
  );

  assign cmd_ready_o = (state_q == B_IDLE);
  assign clearing_o  = (state_q == B_CLEAR);

  // Pick the corner that the current step works on
  always_comb begin
    case (state_q == T_FETCH ? cnt_q[1:0] : j_q)
      2'd1:    corner = cur_q.cb;
      2'd2:    corner = cur_q.cc;
      default: corner = cur_q.ca;
    endcase
  end

  // Signed, scaled edge components and the normalizer input
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sd[i] = dneg_q[i] ? -$signed({1'b0, dmag_q[i][29:0]})
                        :  $signed({1'b0, dmag_q[i][29:0]});
    end
    big_hi = 1'b0;
    for (int i = 0; i < 6; i++) big_hi = big_hi | (|dmag_q[i][32:30]);
    msel = (cnt_q < 3'd6) ? cnt_q : 3'd0;
    for (int i = 0; i < 3; i++) nvec[i] = e_q[i];
    if (state_q == R_NORM) begin
      for (int i = 0; i < 3; i++) begin
        nvec[i] = 64'($signed(rsum_q[95-32*i -: 32]));
      end
    end else if (state_q == R_TAN) begin
      nvec[0] = -64'(nrm_q[2]);
      nvec[1] = '0;
      nvec[2] = 64'(nrm_q[0]);
    end
  end

  // Sequence commands
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    nstart_d    = 1'b0;
    rsum_d      = rsum_q;
    vtx_d       = vtx_q;
    dneg_d      = dneg_q;
    dmag_d      = dmag_q;
    prod_d      = prod_q;
    e_d         = e_q;
    nrm_d       = nrm_q;
    tan_d       = tan_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_o.ready;
    oidx_d      = oidx_q;
    on_d        = on_q;
    ot_d        = ot_q;
    ost_d       = ost_q;
    pos_we      = 1'b0;
    sum_we      = 1'b0;
    pos_raddr   = IDX_W'(corner);
    sum_raddr   = IDX_W'(corner);
    sum_waddr   = IDX_W'(corner);
    sum_wdata   = '0;
    diff        = '0;
    case (state_q)
      B_CLEAR: begin
        // Zero one sum entry a cycle
        sum_we    = 1'b1;
        sum_waddr = clr_q;
        clr_d     = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(VERTEX_DEPTH - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (cmd_valid_i) begin
          cur_d = cmd_i;
          cnt_d = '0;
          case (cmd_i.op)
            svna_pkg::OP_LOAD: begin
              pos_we    = 1'b1;
              sum_we    = 1'b1;
              sum_waddr = IDX_W'(cmd_i.index);
            end
            svna_pkg::OP_TRI: state_d = T_FETCH;
            svna_pkg::OP_READ: begin
              if (cmd_i.in_range) begin
                state_d = R_FETCH;
              end else begin
                for (int i = 0; i < 3; i++) begin
                  nrm_d[i] = '0;
                  tan_d[i] = '0;
                end
                st_d    = svna_pkg::ST_ZERO;
                state_d = R_OUT;
              end
            end
            default: state_d = B_IDLE;
          endcase
        end
      end
      T_FETCH: begin
        if (cnt_q != 3'd0) vtx_d[cnt_q[1:0] - 2'd1] = pos_rd_q;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) state_d = T_DIFF;
      end
      T_DIFF: begin
        for (int k = 0; k < 6; k++) begin
          diff = 33'($signed(vtx_q[k < 3 ? 1 : 2][95-32*(k%3) -: 32]))
               - 33'($signed(vtx_q[0][95-32*(k%3) -: 32]));
          dneg_d[k] = diff[32];
          dmag_d[k] = diff[32] ? 33'(-diff) : 33'(diff);
        end
        state_d = T_SCALE;
      end
      T_SCALE: begin
        // Bring all edge magnitudes below 2^30
        if (big_hi) begin
          for (int k = 0; k < 6; k++) dmag_d[k] = dmag_q[k] >> 1;
        end else begin
          cnt_d = '0;
          for (int i = 0; i < 3; i++) e_d[i] = '0;
          state_d = T_MUL;
        end
      end
      T_MUL: begin
        if (cnt_q != 3'd6) begin
          prod_d = sd[svna_pkg::MUL_A[msel]] * sd[svna_pkg::MUL_B[msel]];
        end
        if (cnt_q != 3'd0) begin
          e_d[svna_pkg::MUL_DST[cnt_q - 3'd1]] = e_q[svna_pkg::MUL_DST[cnt_q - 3'd1]]
            + (svna_pkg::MUL_NEG[cnt_q - 3'd1] ? -64'(prod_q) : 64'(prod_q));
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd6) begin
          nstart_d = 1'b1;
          state_d  = T_NORM;
        end
      end
      T_NORM: begin
        if (ndone) begin
          nrm_d   = nunit;
          j_d     = '0;
          state_d = T_RD;
        end
      end
      T_RD: state_d = T_WR;
      T_WR: begin
        sum_we    = 1'b1;
        sum_wdata = {svna_pkg::sat_add(sum_rd_q[95:64], nrm_q[0]),
                     svna_pkg::sat_add(sum_rd_q[63:32], nrm_q[1]),
                     svna_pkg::sat_add(sum_rd_q[31:0],  nrm_q[2])};
        j_d       = j_q + 2'd1;
        state_d   = (j_q == 2'd2) ? B_IDLE : T_RD;
      end
      R_FETCH: begin
        sum_raddr = IDX_W'(cur_q.index);
        cnt_d     = cnt_q + 3'd1;
        if (cnt_q == 3'd1) begin
          rsum_d   = sum_rd_q;
          nstart_d = 1'b1;
          state_d  = R_NORM;
        end
      end
      R_NORM: begin
        if (ndone) begin
          nrm_d = nunit;
          if (nnz) begin
            nstart_d = 1'b1;
            state_d  = R_TAN;
          end else begin
            for (int i = 0; i < 3; i++) tan_d[i] = '0;
            st_d    = svna_pkg::ST_ZERO;
            state_d = R_OUT;
          end
        end
      end
      R_TAN: begin
        if (ndone) begin
          tan_d   = nunit;
          st_d    = nnz ? svna_pkg::ST_OK : svna_pkg::ST_VERT;
          state_d = R_OUT;
        end
      end
      R_OUT: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          oidx_d      = cur_q.index;
          on_d        = nrm_q;
          ot_d        = tan_q;
          ost_d       = st_q;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Position memory
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[IDX_W'(cmd_i.index)] <= {cmd_i.px, cmd_i.py, cmd_i.pz};
    end
    pos_rd_q <= pos_mem[pos_raddr];
  end

  // Normal-sum memory
  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd_q <= sum_mem[sum_raddr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    j_q    <= j_d;
    rsum_q <= rsum_d;
    vtx_q  <= vtx_d;
    dneg_q <= dneg_d;
    dmag_q <= dmag_d;
    prod_q <= prod_d;
    e_q    <= e_d;
    nrm_q  <= nrm_d;
    tan_q  <= tan_d;
    st_q   <= st_d;
    oidx_q <= oidx_d;
    on_q   <= on_d;
    ot_q   <= ot_d;
    ost_q  <= ost_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      nstart_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      nstart_q    <= nstart_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_index = oidx_q;
  assign out_o.normal_x   = on_q[0];
  assign out_o.normal_y   = on_q[1];
  assign out_o.normal_z   = on_q[2];
  assign out_o.tangent_x  = ot_q[0];
  assign out_o.tangent_y  = ot_q[1];
  assign out_o.tangent_z  = ot_q[2];
  assign out_o.status     = ost_q;

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> !out_valid_q)
    else $error("result present during the clearing pass");
`endif

endmodule

// ----- sv/smooth_vertex_normal_accumulator_unit.sv -----
// Commands: a load is written by the back end directly; a triangle takes one
//   normalization; a read takes two (one for a zero sum, none out of range).
// A normalization runs scale shifts, square steps, root steps and divider steps
//   in that order, all in one shared unit.
// Throughput: one command at a time in the back end; a two-beat queue and the
//   output register let the input side run ahead. Reset: asynchronous, clears
//   control; the sum memory is zeroed entry by entry with input held off.
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator_unit: smooth vertex normal builder
// Stores vertex positions, accumulates unit face normals into per-vertex
// sums and returns normalized vertex normals with their tangents.
// ----------------------------------------------------------------------------
module smooth_vertex_normal_accumulator_unit #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svna_in_if.sink     in_i,
  svna_out_if.source  out_o
);

  logic           cmd_valid, cmd_ready, clearing;
  svna_pkg::cmd_t cmd;

  svna_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .clearing_i  (clearing),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  svna_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .clearing_o  (clearing),
    .out_o       (out_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: smooth vertex normal accumulator check
// Drives position loads, triangles, reads and unused codes with random gaps on
// both channels. A scoreboard keeps its own copy of the position and sum
// stores, predicts each read beat and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH       = 4096;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 1630;

  typedef struct {
    svna_pkg::op_e                     op;
    logic [svna_pkg::IDX_IO_W-1:0]     vi;
    logic signed [svna_pkg::POS_W-1:0] px, py, pz;
    logic [svna_pkg::IDX_IO_W-1:0]     ca, cb, cc;
  } req_t;

  typedef struct {
    logic [svna_pkg::IDX_IO_W-1:0]     idx;
    logic signed [svna_pkg::Q14_W-1:0] vec [6];
    logic [1:0]                        st;
  } normal_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own stores, predicted read beats, checking
  // --------------------------------------------------------------------------
  class normal_scoreboard;
    int           pos_mem [DEPTH][3];
    int           sum_mem [DEPTH][3];
    normal_beat_t expected_q [$];
    int           errors;

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Scale to [2^29, 2^30), take the integer length, round each component.
    static function bit unit_q14(input longint v [3], output int o [3]);
      longint unsigned m [3];
      longint unsigned big, sq, len, q;
      big = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = v[i] < 0 ? -v[i] : v[i];
        if (m[i] > big) big = m[i];
      end
      for (int i = 0; i < 3; i++) o[i] = 0;
      if (big == 0) return 0;
      while (big >= (64'd1 << 30)) begin
        big >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (big < (64'd1 << 29)) begin
        big <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = (m[i] * svna_pkg::ONE_Q14 + len / 2) / len;
        o[i] = v[i] < 0 ? -int'(q) : int'(q);
      end
      return 1;
    endfunction

    function void add_face(int a, int b, int c);
      longint d [6];
      longint e [3];
      longint unsigned m [6];
      longint unsigned big;
      longint s;
      int n [3];
      int corner [3];
      bit ok;
      big = 0;
      for (int i = 0; i < 3; i++) begin
        d[i]     = longint'(pos_mem[b][i]) - longint'(pos_mem[a][i]);
        d[3 + i] = longint'(pos_mem[c][i]) - longint'(pos_mem[a][i]);
      end
      for (int i = 0; i < 6; i++) begin
        m[i] = d[i] < 0 ? -d[i] : d[i];
        if (m[i] > big) big = m[i];
      end
      while (big >= (64'd1 << 30)) begin
        big >>= 1;
        for (int i = 0; i < 6; i++) m[i] >>= 1;
      end
      for (int i = 0; i < 6; i++) d[i] = d[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
      e[0] = d[1] * d[5] - d[2] * d[4];
      e[1] = d[2] * d[3] - d[0] * d[5];
      e[2] = d[0] * d[4] - d[1] * d[3];
      ok = unit_q14(e, n);
      corner = '{a, b, c};
      // Saturating add into all three corner sums
      foreach (corner[k]) begin
        for (int i = 0; i < 3; i++) begin
          s = longint'(sum_mem[corner[k]][i]) + n[i];
          if (s > 64'sd2147483647) s = 64'sd2147483647;
          if (s < -64'sd2147483648) s = -64'sd2147483648;
          sum_mem[corner[k]][i] = int'(s);
        end
      end
    endfunction

    function void note_input(req_t r);
      longint s [3];
      longint t [3];
      int n [3];
      int tg [3];
      normal_beat_t x;
      case (r.op)
        svna_pkg::OP_LOAD: begin
          pos_mem[r.vi] = '{r.px, r.py, r.pz};
          sum_mem[r.vi] = '{0, 0, 0};
        end
        svna_pkg::OP_TRI: add_face(r.ca, r.cb, r.cc);
        svna_pkg::OP_READ: begin
          for (int i = 0; i < 3; i++) s[i] = sum_mem[r.vi][i];
          tg = '{0, 0, 0};
          x.st = svna_pkg::ST_ZERO;
          if (unit_q14(s, n)) begin
            t = '{-longint'(n[2]), 0, longint'(n[0])};
            x.st = unit_q14(t, tg) ? svna_pkg::ST_OK : svna_pkg::ST_VERT;
          end
          x.idx = r.vi;
          x.vec = '{16'(n[0]), 16'(n[1]), 16'(n[2]), 16'(tg[0]), 16'sd0, 16'(tg[2])};
          expected_q.push_back(x);
        end
        default: ;
      endcase
    endfunction

    task check_result(normal_beat_t got);
      normal_beat_t x;
      string names [6] = '{"normal_x", "normal_y", "normal_z",
                           "tangent_x", "tangent_y", "tangent_z"};
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected read beat for vertex %0d", got.idx));
        return;
      end
      x = expected_q.pop_front();
      if (got.idx !== x.idx)
        report($sformatf("read_index got %0d want %0d", got.idx, x.idx));
      foreach (names[i])
        if (got.vec[i] !== x.vec[i])
          report($sformatf("vertex %0d %s got %0d want %0d",
                           x.idx, names[i], got.vec[i], x.vec[i]));
      if (got.st !== x.st)
        report($sformatf("vertex %0d status got %0d want %0d", x.idx, got.st, x.st));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycles;

  svna_in_if  in_bus ();
  svna_out_if out_bus ();

  smooth_vertex_normal_accumulator_unit #(.VERTEX_DEPTH(DEPTH)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  normal_scoreboard sb = new();

  int  loaded_q [$];
  bit  was_loaded [int];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog on the cycle count
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result side: check each beat, then pick the next ready level
  int stall_left;
  always @(posedge clk_i) begin
    normal_beat_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.idx = out_bus.read_index;
      got.vec = '{out_bus.normal_x, out_bus.normal_y, out_bus.normal_z,
                  out_bus.tangent_x, out_bus.tangent_y, out_bus.tangent_z};
      got.st  = out_bus.status;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      stall_left <= gap_len();
      out_bus.ready <= 1'b1;
    end
  end

  // Hold one beat until accepted, then note it
  task automatic drive(req_t r);
    in_bus.valid        <= 1'b1;
    in_bus.operation    <= r.op;
    in_bus.vertex_index <= r.vi;
    in_bus.pos_x        <= r.px;
    in_bus.pos_y        <= r.py;
    in_bus.pos_z        <= r.pz;
    in_bus.corner_a     <= r.ca;
    in_bus.corner_b     <= r.cb;
    in_bus.corner_c     <= r.cc;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_input(r);
    if (r.op == svna_pkg::OP_LOAD && !was_loaded.exists(r.vi)) begin
      was_loaded[r.vi] = 1;
      loaded_q.push_back(r.vi);
    end
  endtask

  task automatic pause();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic req_t noise_req(svna_pkg::op_e op);
    req_t r;
    r.op = op;
    r.vi = 12'($urandom);
    r.px = $urandom;
    r.py = $urandom;
    r.pz = $urandom;
    r.ca = 12'($urandom);
    r.cb = 12'($urandom);
    r.cc = 12'($urandom);
    return r;
  endfunction

  function automatic req_t load_req(int v, int x, int y, int z);
    req_t r;
    r = noise_req(svna_pkg::OP_LOAD);
    r.vi = 12'(v);
    r.px = x;
    r.py = y;
    r.pz = z;
    return r;
  endfunction

  function automatic req_t tri_req(int a, int b, int c);
    req_t r;
    r = noise_req(svna_pkg::OP_TRI);
    r.ca = 12'(a);
    r.cb = 12'(b);
    r.cc = 12'(c);
    return r;
  endfunction

  function automatic req_t read_req(int v);
    req_t r;
    r = noise_req(svna_pkg::OP_READ);
    r.vi = 12'(v);
    return r;
  endfunction

  function automatic int coord();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom;
    if (r < 85) return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    if (r < 92) return 32'sh7fff_ffff;
    return 32'sh8000_0000;
  endfunction

  function automatic int pick_loaded();
    return loaded_q[$urandom_range(loaded_q.size() - 1)];
  endfunction

  initial begin
    req_t r;
    int   v;
    int   waited;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.operation = svna_pkg::OP_NONE;
    in_bus.vertex_index = '0;
    in_bus.pos_x = '0;
    in_bus.pos_y = '0;
    in_bus.pos_z = '0;
    in_bus.corner_a = '0;
    in_bus.corner_b = '0;
    in_bus.corner_c = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: flat face gives a vertical normal and a zero tangent
    drive(load_req(0, 0, 0, 0));
    drive(load_req(1, 32'h0001_0000, 0, 0));
    drive(load_req(2, 0, 0, 32'h0001_0000));
    drive(tri_req(0, 1, 2));
    drive(read_req(0));
    // Extreme positions and extreme indices
    drive(load_req(4095, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    drive(load_req(3, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    drive(load_req(5, 32'sh8000_0000, 32'sh7fff_ffff, 0));
    drive(tri_req(4095, 3, 5));
    drive(read_req(4095));
    drive(read_req(3));
    // Degenerate face adds nothing
    drive(tri_req(1, 1, 2));
    drive(read_req(1));
    // Never touched vertex reads as a zero sum
    drive(read_req(100));
    // Opposite faces cancel
    drive(load_req(6, 12345, -777, 99));
    drive(load_req(7, -50000, 300000, 4));
    drive(load_req(8, 1, 2, -900000));
    drive(tri_req(6, 7, 8));
    drive(tri_req(6, 8, 7));
    drive(read_req(6));
    // Unused code is dropped, reload clears the sum
    drive(noise_req(svna_pkg::OP_NONE));
    drive(load_req(4095, -1, -1, -1));
    drive(read_req(4095));
    pause();

    // Random mesh traffic
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      v = $urandom_range(99);
      if (v < 25) begin
        drive(load_req($urandom_range(99) < 80 ? $urandom_range(0, 47) : $urandom_range(0, 4095),
                       coord(), coord(), coord()));
      end else if (v < 65) begin
        drive(tri_req(pick_loaded(), pick_loaded(), pick_loaded()));
      end else if (v < 95) begin
        drive(read_req($urandom_range(99) < 85 ? pick_loaded() : $urandom_range(0, 4095)));
      end else begin
        drive(noise_req(svna_pkg::OP_NONE));
      end
      pause();
      // Drain everything once midway
      if (n == RANDOM_ITEMS / 2) begin
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
        repeat (300) @(posedge clk_i);
      end
    end
    in_bus.valid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      if (sb.pending() != 0) $display("%0d read beats never arrived", sb.pending());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
